@@ design/bspl_pkg.sv @@
`default_nettype none
package bspl_pkg;

    typedef enum logic [2:0] {
        CMD_WR_PLANE = 3'd0,
        CMD_WR_NODE  = 3'd1,
        CMD_WR_CLIP  = 3'd2,
        CMD_WR_LEAF  = 3'd3,
        CMD_CONTENTS = 3'd4,
        CMD_CAMERA   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_HULL  = 3'd1,
        ST_NODE  = 3'd2,
        ST_PLANE = 3'd3,
        ST_GUARD = 3'd4,
        ST_LEAF  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CFG_ROOT0 = 3'd0,
        CFG_ROOT1 = 3'd1,
        CFG_ROOT2 = 3'd2,
        CFG_ROOT3 = 3'd3,
        CFG_NODES = 3'd4,
        CFG_CLIPS = 3'd5,
        CFG_LEAFS = 3'd6,
        CFG_PLANES = 3'd7
    } cfg_idx_t;

    localparam int SHIFT_DIST = 10;

    // One classified query handed from the front to the back.
    typedef struct packed {
        logic               is_err;    // bad hull, answer immediately
        logic               use_clip;  // walk the clip node table
        logic               want_leaf; // hull 0: read leaf contents
        logic               camera;    // camera query: answer leaf index
        logic signed [15:0] root;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } query_t;

endpackage
`default_nettype wire

@@ design/bsp_point_location_top.sv @@
`default_nettype none
// Channel  Handshake            Payload
// in       valid / ready        command .. hull_select
// out      out_valid/out_ready  status, answer
// cfg      cfg_we               cfg_index, cfg_data
// A write beat is registered into its table. A query leaves the queue, then
// (unless its hull is bad) visits each node: node read, plane read, multiply,
// sum; it makes a final node check, reads the leaf for hull 0 and holds the
// result register until out_ready. A walk visits at most count + 1 nodes,
// each read depending on the last. A two-entry queue takes further queries
// while a walk runs; a table write waits until no query is queued or walking.
// Reset clears the control and configuration registers, not the tables.
module bsp_point_location_top
    import bspl_pkg::*;
#(
    parameter int PLANE_DEPTH = 4096,
    parameter int NODE_DEPTH  = 4096,
    parameter int CLIP_DEPTH  = 4096,
    parameter int LEAF_DEPTH  = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic        [2:0]  command,
    input  wire logic        [11:0] entry_index,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [31:0] plane_offset,
    input  wire logic        [15:0] plane_ref,
    input  wire logic signed [15:0] child_front,
    input  wire logic signed [15:0] child_back,
    input  wire logic signed [31:0] contents_value,
    input  wire logic        [2:0]  hull_select,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [2:0]  status,
    output logic signed      [31:0] answer,
    input  wire logic               cfg_we,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [15:0] cfg_data
);
    logic signed [15:0] root_reg [4];
    logic        [12:0] nodes_reg, clips_reg, leafs_reg, planes_reg;
    query_t             push_q, pop_q;
    logic               push, full, pop, nonempty, twrite;
    logic               walk_busy, back_busy;

    assign back_busy = nonempty || walk_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg[0] <= '0;
            root_reg[1] <= '0;
            root_reg[2] <= '0;
            root_reg[3] <= '0;
            nodes_reg   <= '0;
            clips_reg   <= '0;
            leafs_reg   <= '0;
            planes_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROOT0:  root_reg[0] <= cfg_data;
                CFG_ROOT1:  root_reg[1] <= cfg_data;
                CFG_ROOT2:  root_reg[2] <= cfg_data;
                CFG_ROOT3:  root_reg[3] <= cfg_data;
                CFG_NODES:  nodes_reg   <= cfg_data[12:0];
                CFG_CLIPS:  clips_reg   <= cfg_data[12:0];
                CFG_LEAFS:  leafs_reg   <= cfg_data[12:0];
                CFG_PLANES: planes_reg  <= cfg_data[12:0];
                default:    nodes_reg   <= nodes_reg;
            endcase
        end
    end

    bspl_front u_front (
        .valid(valid), .ready(ready), .command(command),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .hull_select(hull_select),
        .root0(root_reg[0]), .root1(root_reg[1]), .root2(root_reg[2]),
        .root3(root_reg[3]), .queue_full(full), .back_busy(back_busy),
        .push(push), .query(push_q), .table_write(twrite)
    );

    bspl_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_q), .full(full),
        .pop(pop), .pop_data(pop_q), .nonempty(nonempty)
    );

    bspl_back #(
        .PLANE_DEPTH(PLANE_DEPTH), .NODE_DEPTH(NODE_DEPTH),
        .CLIP_DEPTH(CLIP_DEPTH), .LEAF_DEPTH(LEAF_DEPTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_nonempty(nonempty), .q_data(pop_q),
        .q_pop(pop), .busy(walk_busy), .wr_valid(twrite), .command(command),
        .entry_index(entry_index), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .plane_offset(plane_offset), .plane_ref(plane_ref),
        .child_front(child_front), .child_back(child_back),
        .contents_value(contents_value), .node_count(nodes_reg),
        .clip_count(clips_reg), .leaf_count(leafs_reg), .plane_count(planes_reg),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .answer(answer)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> answer == 0)
        else $error("Error beat carries a nonzero answer.");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Query pushed into a full queue.");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("Query popped from an empty queue.");
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        twrite |-> !back_busy)
        else $error("Table write taken while a query is in flight.");
endmodule
`default_nettype wire

@@ design/bspl_ram.sv @@
`default_nettype none
module bspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/bspl_queue.sv @@
`default_nettype none
module bspl_queue
    import bspl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  query_t      push_data,
    output logic        full,
    input  wire logic   pop,
    output query_t      pop_data,
    output logic        nonempty
);
    query_t     slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       rd_reg;
    logic       wr_reg;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

@@ design/bspl_front.sv @@
`default_nettype none
module bspl_front
    import bspl_pkg::*;
(
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic        [2:0]  command,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic        [2:0]  hull_select,
    input  wire logic signed [15:0] root0,
    input  wire logic signed [15:0] root1,
    input  wire logic signed [15:0] root2,
    input  wire logic signed [15:0] root3,
    input  wire logic               queue_full,
    input  wire logic               back_busy,
    output logic                    push,
    output query_t                  query,
    output logic                    table_write
);
    logic is_query;

    // A table write must not overtake a query that is still queued or walking.
    assign is_query    = (command == CMD_CONTENTS) || (command == CMD_CAMERA);
    assign ready       = is_query ? !queue_full : !back_busy;
    assign push        = valid && ready && is_query;
    assign table_write = valid && ready && !is_query;

    always_comb
    begin
        query           = '0;
        query.x         = vec_x;
        query.y         = vec_y;
        query.z         = vec_z;
        query.camera    = (command == CMD_CAMERA);
        query.is_err    = (command == CMD_CONTENTS) && (hull_select > 3'd3);
        query.use_clip  = (command == CMD_CONTENTS) && (hull_select != 3'd0);
        query.want_leaf = (command == CMD_CONTENTS) && (hull_select == 3'd0);
        case (hull_select)
            3'd0:    query.root = root0;
            3'd1:    query.root = root1;
            3'd2:    query.root = root2;
            3'd3:    query.root = root3;
            default: query.root = '0;
        endcase
        if (command == CMD_CAMERA)
        begin
            query.root = '0;
        end
    end
endmodule
`default_nettype wire

@@ design/bspl_back.sv @@
`default_nettype none
module bspl_back
    import bspl_pkg::*;
#(
    parameter int PLANE_DEPTH = 4096,
    parameter int NODE_DEPTH  = 4096,
    parameter int CLIP_DEPTH  = 4096,
    parameter int LEAF_DEPTH  = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_nonempty,
    input  query_t                  q_data,
    output logic                    q_pop,
    output logic                    busy,
    input  wire logic               wr_valid,
    input  wire logic        [2:0]  command,
    input  wire logic        [11:0] entry_index,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [31:0] plane_offset,
    input  wire logic        [15:0] plane_ref,
    input  wire logic signed [15:0] child_front,
    input  wire logic signed [15:0] child_back,
    input  wire logic signed [31:0] contents_value,
    input  wire logic        [12:0] node_count,
    input  wire logic        [12:0] clip_count,
    input  wire logic        [12:0] leaf_count,
    input  wire logic        [12:0] plane_count,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [2:0]  status,
    output logic signed      [31:0] answer
);
    localparam int PW = $clog2(PLANE_DEPTH);
    localparam int NW = $clog2(NODE_DEPTH);
    localparam int CW = $clog2(CLIP_DEPTH);
    localparam int LW = $clog2(LEAF_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_NODE  = 8'b00000010,
        S_PLANE = 8'b00000100,
        S_MUL   = 8'b00001000,
        S_SUM   = 8'b00010000,
        S_LEAF  = 8'b00100000,
        S_LDATA = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t             state_reg, state_next;
    query_t             cur_reg;
    logic signed [15:0] node_reg;
    logic        [16:0] guard_reg;
    logic        [13:0] count_sel;
    logic        [13:0] pcount;
    logic        [13:0] lcount;
    logic        [2:0]  status_reg;
    logic signed [31:0] answer_reg;
    logic signed [47:0] prod_reg [3];
    logic signed [47:0] offs_reg;
    logic signed [15:0] fch_reg;
    logic signed [15:0] bch_reg;

    logic [47:0] node_wdata;
    logic [47:0] node_rdata;
    logic [47:0] clip_rdata;
    logic [47:0] norm_rdata;
    logic [31:0] offs_rdata;
    logic [31:0] leaf_rdata;
    logic [47:0] entry;
    logic [15:0] pidx;
    logic signed [15:0] li16;
    logic signed [49:0] dsum;
    logic signed [15:0] next_node;

    assign node_wdata = {child_back, child_front, plane_ref};

    bspl_ram #(.WIDTH(48), .DEPTH(PLANE_DEPTH)) u_norm (
        .clk(clk),
        .we(wr_valid && command == CMD_WR_PLANE && 32'(entry_index) < PLANE_DEPTH),
        .waddr(PW'(entry_index)),
        .wdata({vec_z[15:0], vec_y[15:0], vec_x[15:0]}),
        .raddr(PW'(pidx)),
        .rdata(norm_rdata)
    );
    bspl_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_offs (
        .clk(clk),
        .we(wr_valid && command == CMD_WR_PLANE && 32'(entry_index) < PLANE_DEPTH),
        .waddr(PW'(entry_index)),
        .wdata(plane_offset),
        .raddr(PW'(pidx)),
        .rdata(offs_rdata)
    );
    bspl_ram #(.WIDTH(48), .DEPTH(NODE_DEPTH)) u_node (
        .clk(clk),
        .we(wr_valid && command == CMD_WR_NODE && 32'(entry_index) < NODE_DEPTH),
        .waddr(NW'(entry_index)),
        .wdata(node_wdata),
        .raddr(NW'(node_reg)),
        .rdata(node_rdata)
    );
    bspl_ram #(.WIDTH(48), .DEPTH(CLIP_DEPTH)) u_clip (
        .clk(clk),
        .we(wr_valid && command == CMD_WR_CLIP && 32'(entry_index) < CLIP_DEPTH),
        .waddr(CW'(entry_index)),
        .wdata(node_wdata),
        .raddr(CW'(node_reg)),
        .rdata(clip_rdata)
    );
    bspl_ram #(.WIDTH(32), .DEPTH(LEAF_DEPTH)) u_leaf (
        .clk(clk),
        .we(wr_valid && command == CMD_WR_LEAF && 32'(entry_index) < LEAF_DEPTH),
        .waddr(LW'(entry_index)),
        .wdata(contents_value),
        .raddr(LW'(li16)),
        .rdata(leaf_rdata)
    );

    assign entry = cur_reg.use_clip ? clip_rdata : node_rdata;
    assign pidx  = entry[15:0];
    assign li16  = -16'sd1 - node_reg;

    always_comb
    begin
        if (cur_reg.use_clip)
        begin
            count_sel = (32'(clip_count) > CLIP_DEPTH) ? 14'(CLIP_DEPTH) : 14'(clip_count);
        end
        else
        begin
            count_sel = (32'(node_count) > NODE_DEPTH) ? 14'(NODE_DEPTH) : 14'(node_count);
        end
        pcount = (32'(plane_count) > PLANE_DEPTH) ? 14'(PLANE_DEPTH) : 14'(plane_count);
        lcount = (32'(leaf_count) > LEAF_DEPTH) ? 14'(LEAF_DEPTH) : 14'(leaf_count);
    end

    assign dsum = 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(prod_reg[2]) - 50'(offs_reg);
    assign next_node = dsum[49] ? bch_reg : fch_reg;

    assign q_pop     = (state_reg == S_IDLE) && q_nonempty;
    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign answer    = answer_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (q_nonempty) state_next = S_NODE;
            S_NODE:
            begin
                if (node_reg < 0)
                begin
                    state_next = cur_reg.want_leaf ? S_LEAF : S_OUT;
                end
                else if (guard_reg > 17'(count_sel) || 17'(node_reg) >= 17'(count_sel))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PLANE;
                end
            end
            S_PLANE: state_next = (17'(pidx) >= 17'(pcount)) ? S_OUT : S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_NODE;
            S_LEAF:  state_next = (17'(li16) >= 17'(lcount)) ? S_OUT : S_LDATA;
            S_LDATA: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && q_nonempty && q_data.is_err)
        begin
            state_next = S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cur_reg    <= q_data;
                node_reg   <= q_data.root;
                guard_reg  <= '0;
                answer_reg <= '0;
                status_reg <= q_data.is_err ? ST_HULL : ST_OK;
            end
            S_NODE:
            begin
                if (node_reg < 0)
                begin
                    if (cur_reg.camera)
                    begin
                        answer_reg <= 32'(li16);
                    end
                    else if (!cur_reg.want_leaf)
                    begin
                        answer_reg <= 32'(node_reg);
                    end
                end
                else if (guard_reg > 17'(count_sel))
                begin
                    status_reg <= ST_GUARD;
                end
                else if (17'(node_reg) >= 17'(count_sel))
                begin
                    status_reg <= ST_NODE;
                end
                guard_reg <= guard_reg + 17'd1;
            end
            S_PLANE:
            begin
                if (17'(pidx) >= 17'(pcount))
                begin
                    status_reg <= ST_PLANE;
                end
                fch_reg <= entry[31:16];
                bch_reg <= entry[47:32];
            end
            S_MUL:
            begin
                prod_reg[0] <= $signed(norm_rdata[15:0]) * cur_reg.x;
                prod_reg[1] <= $signed(norm_rdata[31:16]) * cur_reg.y;
                prod_reg[2] <= $signed(norm_rdata[47:32]) * cur_reg.z;
                offs_reg    <= 48'($signed(offs_rdata)) <<< SHIFT_DIST;
            end
            S_SUM:
            begin
                node_reg <= next_node;
            end
            S_LEAF:
            begin
                if (17'(li16) >= 17'(lcount))
                begin
                    status_reg <= ST_LEAF;
                end
            end
            S_LDATA:
            begin
                answer_reg <= leaf_rdata;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire
